>>> sv/mte_pkg.sv
// Package for the multi-tap echo delay: field widths, register indexes,
// sequencer states and rounding constants. No dependencies.
`default_nettype none

package mte_pkg;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 15;
  localparam int COUNT_W   = 4;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;

  // Accumulator covers dry*2^15 plus up to sixteen full-scale echoes
  localparam int ACC_W = 40;

  // Q1.15 round half up
  localparam int FRAC_W     = 15;
  localparam int ROUND_HALF = 16384;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX   = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0]   DELAY_RST = 15'd16538;
  localparam logic [COUNT_W-1:0] COUNT_RST = 4'd10;
  localparam logic [GAIN_W-1:0]  DECAY_RST = 15'd16384;
  localparam logic [GAIN_W-1:0]  MIX_RST   = 15'd26214;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_DONE
  } seq_state_e;

endpackage

`default_nettype wire

>>> sv/multi_tap_echo_delay_core.sv
// Multi-tap echo delay: one item at a time; a new item is taken only in idle, after the last
// result has been loaded into the output register. N = echo count capped at MAX_ECHOES.
// The single read port of the history memory reads one echo tap per cycle for the N taps;
// the states DRAIN1 and DRAIN2 empty the read and multiply stages, DONE rounds and saturates
// into the output register and holds while the output stalls, and idle takes the item.
// Reset clears the sequencer, write pointer and fill count and loads register defaults;
// history contents stay undefined and are never used before written, so no clearing pass.
`default_nettype none

module multi_tap_echo_delay_core #(
  parameter int HISTORY_DEPTH = 262144,
  parameter int MAX_ECHOES    = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mte_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mte_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mte_pkg::SAMPLE_W-1:0]  in_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mte_pkg::SAMPLE_W-1:0]  out_sample_o
);
  import mte_pkg::*;

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int SSW  = $clog2(HISTORY_DEPTH + 1);
  localparam int KW   = $clog2(MAX_ECHOES + 1);
  localparam int OFFW = GAIN_W + KW;
  localparam int CMPW = ((OFFW > SSW) ? OFFW : SSW) + 1;
  localparam int GPW  = 2 * GAIN_W + 1;

  localparam logic [AW-1:0]   LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [SSW-1:0]  SEEN_MAX  = SSW'(HISTORY_DEPTH);
  localparam logic [AW:0]     DEPTH_EXT = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(HISTORY_DEPTH);
  localparam logic [4:0]      MAX_CNT5  = 5'(MAX_ECHOES);

  // Configuration registers
  logic [CFG_W-1:0]   delay_q;
  logic [COUNT_W-1:0] count_q;
  logic [GAIN_W-1:0]  decay_q;
  logic [GAIN_W-1:0]  mix_q;

  // Sequencer and control state
  seq_state_e     state_q, state_d;
  logic [AW-1:0]  wp_q;
  logic [AW-1:0]  base_q;
  logic [SSW-1:0] seen_q;
  logic [KW-1:0]  k_q;
  logic [KW-1:0]  cnt_q;
  logic           tap_vld_q;
  logic           prod_vld_q;
  logic           out_valid_q;

  // Datapath registers
  logic [GAIN_W-1:0]          gain_q;
  logic [GAIN_W-1:0]          tap_gain_q;
  logic [OFFW-1:0]            off_q;
  logic signed [2*SAMPLE_W-1:0] prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;

  // Combinational signals
  logic                       in_acc;
  logic                       issue;
  logic                       load_out;
  logic [4:0]                 cnt_ext;
  logic [4:0]                 cnt_lim;
  logic [KW-1:0]              cnt_now;
  logic [KW-1:0]              k_nx;
  logic [GPW-1:0]             gprod;
  logic [GAIN_W-1:0]          gain_nx;
  logic [OFFW-1:0]            off_nx;
  logic                       tap_ok;
  logic [AW:0]                diff;
  logic [AW:0]                diff_wrap;
  logic [AW-1:0]              src_addr;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    shifted;
  logic                       sat_hi;
  logic                       sat_lo;
  logic signed [SAMPLE_W-1:0] res;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RST;
      count_q <= COUNT_RST;
      decay_q <= DECAY_RST;
      mix_q   <= MIX_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DELAY: delay_q <= cfg_data_i;
        CFG_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_DECAY: decay_q <= cfg_data_i;
        CFG_MIX:   mix_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Cap echo count at MAX_ECHOES
  assign cnt_ext = {1'b0, count_q};
  assign cnt_lim = (cnt_ext > MAX_CNT5) ? MAX_CNT5 : cnt_ext;
  assign cnt_now = KW'(cnt_lim);

  assign in_acc = in_valid_i && (state_q == ST_IDLE);
  assign k_nx   = k_q + KW'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (cnt_now != '0) ? ST_RUN : ST_DRAIN1;
        end
      end
      ST_RUN: begin
        if (k_nx == cnt_q) begin
          state_d = ST_DRAIN1;
        end
      end
      ST_DRAIN1: state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_RUN:  issue      = 1'b1;
      ST_DONE: load_out   = !out_valid_q || !out_stall_i;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Gain recursion: c(k) = (c(k-1)*decay + half) >> 15
  assign gprod   = gain_q * decay_q + GPW'(ROUND_HALF);
  assign gain_nx = gprod[2*GAIN_W-1:FRAC_W];

  // Tap offset, fill check and wrapped source address
  assign off_nx    = off_q + OFFW'(delay_q);
  assign tap_ok    = (CMPW'(off_nx) < CMPW'(seen_q)) && (CMPW'(off_nx) < DEPTH_CMP);
  assign diff      = {1'b0, base_q} - (AW + 1)'(off_nx);
  assign diff_wrap = diff + DEPTH_EXT;
  assign src_addr  = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];

  // Pointer, fill count and tap counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      seen_q     <= '0;
      k_q        <= '0;
      tap_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        wp_q <= (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
        if (seen_q != SEEN_MAX) begin
          seen_q <= seen_q + SSW'(1);
        end
        k_q <= '0;
      end else if (issue) begin
        k_q <= k_nx;
      end
      tap_vld_q  <= issue && tap_ok;
      prod_vld_q <= tap_vld_q;
    end
  end

  // Tap pipeline: gain and address, multiply, accumulate
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      base_q <= wp_q;
      cnt_q  <= cnt_now;
      gain_q <= mix_q;
      off_q  <= '0;
      acc_q  <= ACC_W'(in_sample_i) <<< FRAC_W;
    end else begin
      if (issue) begin
        gain_q     <= gain_nx;
        tap_gain_q <= gain_nx;
        off_q      <= off_nx;
      end
      if (prod_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
    prod_q <= rd_data * $signed({1'b0, tap_gain_q});
  end

  mte_hist_mem #(
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(wp_q),
    .wdata_i(in_sample_i),
    .re_i   (issue),
    .raddr_i(src_addr),
    .rdata_o(rd_data)
  );

  // Round half up and saturate
  assign rnd     = acc_q + ACC_W'(ROUND_HALF);
  assign shifted = rnd >>> FRAC_W;
  assign sat_hi  = !shifted[ACC_W-1] && (|shifted[ACC_W-2:SAMPLE_W-1]);
  assign sat_lo  = shifted[ACC_W-1] && !(&shifted[ACC_W-2:SAMPLE_W-1]);

  always_comb begin
    if (sat_hi) begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (sat_lo) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res = shifted[SAMPLE_W-1:0];
    end
  end

  // Output register; holds while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_sample_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;

  // Checks
  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (k_q < cnt_q))
    else $error("tap issued beyond echo count");

  a_seen_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SEEN_MAX)
    else $error("fill count above history depth");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN || state_q == ST_DRAIN1))
    else $error("accepted item did not start the tap sequence");

  a_prod_follows_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_vld_q |-> $past(tap_vld_q))
    else $error("product valid without a tap read");

endmodule

`default_nettype wire

>>> sv/mte_hist_mem.sv
// Sample history memory: one write port, one read port, registered read data.
// Depends on mte_pkg for the sample width.
`default_nettype none

module mte_hist_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [$clog2(DEPTH)-1:0]            waddr_i,
  input  logic signed [mte_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic                                re_i,
  input  logic [$clog2(DEPTH)-1:0]            raddr_i,
  output logic signed [mte_pkg::SAMPLE_W-1:0] rdata_o
);
  import mte_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;

  // Write incoming sample
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read tap; read data is registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> tb/sv/multi_tap_echo_delay_core_tb.sv
// Self-checking testbench for multi_tap_echo_delay_core: directed table, then random phases.
// Expected samples come from the table where a row gives one, else from a behavioural echo mixer.
// Depends on mte_pkg and multi_tap_echo_delay_core.
`default_nettype none

module multi_tap_echo_delay_core_tb;
  import mte_pkg::*;

  localparam int HIST_DEPTH   = 262144;
  localparam int MAX_TAPS     = 10;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASES       = 16;
  localparam int PHASE_ITEMS  = 106;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [CFG_IDX_W-1:0]        idx;
    logic [CFG_W-1:0]            data;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        typed;
    logic signed [SAMPLE_W-1:0]  want;
  } dir_row_t;

  localparam int NDIR = 34;
  localparam dir_row_t DIR_TAB [NDIR] = '{
    // reset settings: echo sources lie before the first sample, so dry passes through
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd0,      1'b1, 16'sd0},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd32767,  1'b1, 16'sd32767},
    '{ROW_ITEM, CFG_DELAY, 15'd0, -16'sd32768, 1'b1, -16'sd32768},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd1,      1'b1, 16'sd1},
    '{ROW_ITEM, CFG_DELAY, 15'd0, -16'sd1,     1'b1, -16'sd1},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd21845,  1'b1, 16'sd21845},
    '{ROW_ITEM, CFG_DELAY, 15'd0, -16'sd21846, 1'b1, -16'sd21846},
    // zero delay with full gains: every echo reads the current sample, full-scale inputs saturate
    '{ROW_CFG,  CFG_DELAY, 15'd0,     16'sd0, 1'b0, 16'sd0},
    '{ROW_CFG,  CFG_DECAY, 15'd32767, 16'sd0, 1'b0, 16'sd0},
    '{ROW_CFG,  CFG_MIX,   15'd32767, 16'sd0, 1'b0, 16'sd0},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd32767,  1'b1, 16'sd32767},
    '{ROW_ITEM, CFG_DELAY, 15'd0, -16'sd32768, 1'b1, -16'sd32768},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd0,      1'b1, 16'sd0},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd100,    1'b0, 16'sd0},
    // echo count above the cap, zero wet gain: echoes weigh nothing
    '{ROW_CFG,  CFG_COUNT, 15'h7fff,  16'sd0, 1'b0, 16'sd0},
    '{ROW_CFG,  CFG_DELAY, 15'd1,     16'sd0, 1'b0, 16'sd0},
    '{ROW_CFG,  CFG_MIX,   15'd0,     16'sd0, 1'b0, 16'sd0},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd1234,   1'b1, 16'sd1234},
    '{ROW_ITEM, CFG_DELAY, 15'd0, -16'sd7,     1'b1, -16'sd7},
    // short delay, two echoes at half decay
    '{ROW_CFG,  CFG_DELAY, 15'd3,     16'sd0, 1'b0, 16'sd0},
    '{ROW_CFG,  CFG_MIX,   15'd32767, 16'sd0, 1'b0, 16'sd0},
    '{ROW_CFG,  CFG_DECAY, 15'd16384, 16'sd0, 1'b0, 16'sd0},
    '{ROW_CFG,  CFG_COUNT, 15'd2,     16'sd0, 1'b0, 16'sd0},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd4000,   1'b0, 16'sd0},
    '{ROW_ITEM, CFG_DELAY, 15'd0, -16'sd4000,  1'b0, 16'sd0},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd300,    1'b0, 16'sd0},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd32767,  1'b0, 16'sd0},
    '{ROW_ITEM, CFG_DELAY, 15'd0, -16'sd12,    1'b0, 16'sd0},
    // no echoes at all
    '{ROW_CFG,  CFG_COUNT, 15'd0,     16'sd0, 1'b0, 16'sd0},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd32767,  1'b1, 16'sd32767},
    '{ROW_ITEM, CFG_DELAY, 15'd0, -16'sd32768, 1'b1, -16'sd32768},
    // widest spacing: every source lies before the first sample
    '{ROW_CFG,  CFG_DELAY, 15'd32767, 16'sd0, 1'b0, 16'sd0},
    '{ROW_CFG,  CFG_COUNT, 15'd10,    16'sd0, 1'b0, 16'sd0},
    '{ROW_ITEM, CFG_DELAY, 15'd0, 16'sd555,    1'b1, 16'sd555}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [CFG_W-1:0]            cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic signed [SAMPLE_W-1:0]  in_sample_i;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0]  out_sample_o;

  // Mixer state and register copies
  logic signed [SAMPLE_W-1:0]  hist_mem [HIST_DEPTH];
  int                          wr_ptr;
  int                          fill_cnt;
  logic [CFG_W-1:0]            m_delay;
  logic [COUNT_W-1:0]          m_count;
  logic [GAIN_W-1:0]           m_decay;
  logic [GAIN_W-1:0]           m_mix;

  logic signed [SAMPLE_W-1:0]  expected_out_q [$];
  int                          err_cnt;
  int                          send_idle_pct;
  int                          recv_stall_pct;

  multi_tap_echo_delay_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_sample_i  (in_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_sample_o (out_sample_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Store the dry sample, add the weighted echoes, round and saturate
  function automatic logic signed [SAMPLE_W-1:0] mix_echoes(input logic signed [SAMPLE_W-1:0] dry);
    longint acc;
    longint gain;
    longint offset;
    longint res;
    int     src;
    int     taps;
    int     k;
    hist_mem[wr_ptr] = dry;
    if (fill_cnt < HIST_DEPTH) fill_cnt++;
    taps = (m_count > MAX_TAPS) ? MAX_TAPS : int'(m_count);
    acc  = longint'(dry) * 32768;
    gain = longint'(m_mix);
    for (k = 1; k <= taps; k++) begin
      offset = longint'(k) * longint'(m_delay);
      gain   = (gain * longint'(m_decay) + ROUND_HALF) >>> FRAC_W;
      if (offset < fill_cnt && offset < HIST_DEPTH) begin
        src = (wr_ptr >= offset) ? int'(wr_ptr - offset) : int'(wr_ptr + HIST_DEPTH - offset);
        acc += gain * longint'(hist_mem[src]);
      end
    end
    wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    res = (acc + ROUND_HALF) >>> FRAC_W;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[SAMPLE_W-1:0];
  endfunction

  // Write one register and mirror it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_DELAY: m_delay = data;
      CFG_COUNT: m_count = data[COUNT_W-1:0];
      CFG_DECAY: m_decay = data;
      default:   m_mix   = data;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one item, hold it until accepted, then log its expected sample
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic typed,
                             input logic signed [SAMPLE_W-1:0] want);
    logic signed [SAMPLE_W-1:0] pred;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_sample_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = mix_echoes(s);
    expected_out_q.push_back(typed ? want : pred);
  endtask

  // Drop valid and wait until the block is idle
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_out_q.size() == 0) begin
        $error("out_sample: no item expected, actual %0d", out_sample_o);
        err_cnt++;
      end else begin
        if (out_sample_o !== expected_out_q[0]) begin
          $error("out_sample: expected %0d, actual %0d", expected_out_q[0], out_sample_o);
          err_cnt++;
        end
        void'(expected_out_q.pop_front());
      end
    end
  end

  initial begin
    #30_000_000;
    $display("[multi_tap_echo_delay_core] ERROR");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0]           dly;
    logic [COUNT_W-1:0]         cnt;
    logic [GAIN_W-1:0]          g;
    logic signed [SAMPLE_W-1:0] s;
    int                         sel;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_DELAY;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    in_sample_i    = '0;
    err_cnt        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wr_ptr         = 0;
    fill_cnt       = 0;
    m_delay        = DELAY_RST;
    m_count        = COUNT_RST;
    m_decay        = DECAY_RST;
    m_mix          = MIX_RST;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        drain();
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
      end else begin
        send_sample(DIR_TAB[i].sample, DIR_TAB[i].typed, DIR_TAB[i].want);
      end
    end

    // Random phases: fresh settings each time and one of four idling patterns in turn
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 10)      dly = '0;
      else if (sel < 70) dly = CFG_W'($urandom_range(1, 40));
      else if (sel < 90) dly = CFG_W'($urandom_range(41, 300));
      else               dly = CFG_W'($urandom_range(301, 32767));
      write_reg(CFG_DELAY, dly);
      cnt = COUNT_W'($urandom_range(0, 15));
      write_reg(CFG_COUNT, {11'($urandom), cnt});
      sel = $urandom_range(0, 99);
      g = (sel < 20) ? '0 : (sel < 40) ? '1 : GAIN_W'($urandom);
      write_reg(CFG_DECAY, g);
      sel = $urandom_range(0, 99);
      g = (sel < 20) ? '0 : (sel < 40) ? '1 : GAIN_W'($urandom);
      write_reg(CFG_MIX, g);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 50)      s = SAMPLE_W'($urandom);
        else if (sel < 85) s = SAMPLE_W'($urandom_range(0, 8191)) - 16'sd4096;
        else if (sel < 93) s = 16'sd32767;
        else               s = -16'sd32768;
        send_sample(s, 1'b0, '0);
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("[multi_tap_echo_delay_core] OK");
    end else begin
      $display("[multi_tap_echo_delay_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
